[hdl/sma_pkg.sv]
// Shared types, widths and helpers of the spectral magnitude averager.
`default_nettype none
package sma_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int MAG_W     = 16;
	localparam int HW_W      = 5;
	localparam int ADDR_W    = 6;
	localparam int MEM_DEPTH = 64;
	localparam int FILL_W    = 7;
	localparam int SUM_W     = 22;
	localparam int DVD_W     = 32;
	localparam int DSR_W     = 16;
	localparam int CNT_W     = 5;
	localparam int Q_DEPTH   = 4;
	localparam int QPTR_W    = 2;

	// One bin with its magnitude, handed from the front to the back.
	typedef struct packed {
		logic [MAG_W-1:0]           mag;
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
		logic                       last;
	} item_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quot;
	} div_rsp_t;

	function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAMPLE_W+1:0] v);
		logic signed [SAMPLE_W+1:0] hi;
		logic signed [SAMPLE_W+1:0] lo;
		hi = 18'sd32767;
		lo = -18'sd32768;
		if (v > hi) begin
			return 16'sh7fff;
		end else if (v < lo) begin
			return 16'sh8000;
		end
		return v[SAMPLE_W-1:0];
	endfunction

endpackage
`default_nettype wire

[hdl/sma_front.sv]
// Front part: takes a bin and works out its integer magnitude bit pair by bit pair.
`default_nettype none
module sma_front (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire  signed [sma_pkg::SAMPLE_W-1:0]   in_re,
	input  wire  signed [sma_pkg::SAMPLE_W-1:0]   in_im,
	input  wire                                   in_last,
	output logic                                  push,
	output sma_pkg::item_t                        push_item,
	input  wire                                   q_full
);

	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_SQ   = 5'b00010,
		F_SUM  = 5'b00100,
		F_ITER = 5'b01000,
		F_PUSH = 5'b10000
	} fstate_t;

	fstate_t state_q;
	logic signed [sma_pkg::SAMPLE_W-1:0] re_q, im_q;
	logic last_q;
	logic signed [31:0] sqr_s1, sqi_s1;
	logic [31:0] x_q, res_q, bit_q, trial;
	logic [3:0] iter_q;

	assign in_ready = (state_q == F_IDLE);
	assign push     = (state_q == F_PUSH) && !q_full;
	assign trial    = res_q + bit_q;

	always_comb begin
		push_item.mag  = res_q[sma_pkg::MAG_W-1:0];
		push_item.re   = re_q;
		push_item.im   = im_q;
		push_item.last = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: if (in_valid) state_q <= F_SQ;
				F_SQ:   state_q <= F_SUM;
				F_SUM: begin
					iter_q  <= '0;
					state_q <= F_ITER;
				end
				F_ITER: begin
					iter_q <= iter_q + 4'd1;
					if (iter_q == 4'd15) state_q <= F_PUSH;
				end
				F_PUSH: if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			re_q   <= in_re;
			im_q   <= in_im;
			last_q <= in_last;
		end
		if (state_q == F_SQ) begin
			sqr_s1 <= re_q * re_q;
			sqi_s1 <= im_q * im_q;
		end
		if (state_q == F_SUM) begin
			x_q   <= sqr_s1 + sqi_s1;
			res_q <= '0;
			bit_q <= 32'h4000_0000;
		end
		if (state_q == F_ITER) begin
			// one root bit per step
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule
`default_nettype wire

[hdl/sma_queue.sv]
// Short queue of magnitude items between front and back.
`default_nettype none
module sma_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  sma_pkg::item_t        push_item,
	output logic                  full,
	input  wire                   pop,
	output sma_pkg::item_t        head,
	output logic                  empty
);

	sma_pkg::item_t slot_q [sma_pkg::Q_DEPTH];
	logic [sma_pkg::QPTR_W-1:0] wptr_q, rptr_q;
	logic [sma_pkg::QPTR_W:0] count_q;

	assign full  = (count_q == 3'(sma_pkg::Q_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= push_item;
	end

endmodule
`default_nettype wire

[hdl/sma_div.sv]
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module sma_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sma_pkg::div_req_t   req,
	output sma_pkg::div_rsp_t   rsp
);

	logic [sma_pkg::DVD_W-1:0] dvd_q;
	logic [sma_pkg::DSR_W-1:0] dsr_q, rem_q;
	logic [sma_pkg::CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [sma_pkg::DSR_W:0] trial, diff;
	logic ge;

	assign trial = {rem_q, dvd_q[sma_pkg::DVD_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_comb begin
		rsp.busy = busy_q;
		rsp.done = done_q;
		rsp.quot = dvd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[sma_pkg::DSR_W-1:0] : trial[sma_pkg::DSR_W-1:0];
			dvd_q <= {dvd_q[sma_pkg::DVD_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

[hdl/sma_back.sv]
// Back part: magnitude window memory, running sum, frame flush and output scaling.
`default_nettype none
module sma_back (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire  [sma_pkg::HW_W-1:0]             half_width,
	input  wire                                  rc_req,
	input  wire                                  q_empty,
	output logic                                 q_pop,
	input  sma_pkg::item_t                       q_item,
	output sma_pkg::div_req_t                    div_req,
	input  sma_pkg::div_rsp_t                    div_rsp,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [sma_pkg::SAMPLE_W-1:0]  out_re,
	output logic signed [sma_pkg::SAMPLE_W-1:0]  out_im,
	output logic                                 out_last
);

	typedef enum logic [14:0] {
		B_IDLE   = 15'b000000000000001,
		B_RC_RD  = 15'b000000000000010,
		B_RC_ACC = 15'b000000000000100,
		B_SHIFT  = 15'b000000000001000,
		B_ACC    = 15'b000000000010000,
		B_CAP    = 15'b000000000100000,
		B_DAVG   = 15'b000000001000000,
		B_MRE    = 15'b000000010000000,
		B_SRE    = 15'b000000100000000,
		B_DRE    = 15'b000001000000000,
		B_MIM    = 15'b000010000000000,
		B_SIM    = 15'b000100000000000,
		B_DIM    = 15'b001000000000000,
		B_OUT    = 15'b010000000000000,
		B_NEXT   = 15'b100000000000000
	} bstate_t;

	localparam int ENT_W = sma_pkg::MAG_W + 2 * sma_pkg::SAMPLE_W;

	bstate_t state_q;
	logic [ENT_W-1:0] mem [sma_pkg::MEM_DEPTH];
	logic [ENT_W-1:0] rd_q;
	logic mem_we, mem_re;
	logic [sma_pkg::ADDR_W-1:0] mem_wa, mem_ra;

	logic [sma_pkg::ADDR_W-1:0] wp_q, idx_q;
	logic [sma_pkg::FILL_W-1:0] fill_q;
	logic [sma_pkg::SUM_W-1:0]  sum_q;
	logic [sma_pkg::HW_W-1:0]   flush_q;
	logic rc_pend_q, last_q, elast_q;
	sma_pkg::item_t cur_q;
	logic [sma_pkg::MAG_W-1:0] ctr_mag_q, avg_q;
	logic signed [sma_pkg::SAMPLE_W-1:0] ctr_re_q, ctr_im_q, ore_q, oim_q;
	logic signed [31:0] prod_s1, prod_abs;
	logic neg_q;
	logic out_valid_q, out_last_q;
	logic signed [sma_pkg::SAMPLE_W-1:0] out_re_q, out_im_q;

	logic [sma_pkg::ADDR_W-1:0] two_h;
	logic [sma_pkg::FILL_W-1:0] span;
	logic [sma_pkg::MAG_W-1:0]  rd_mag;
	logic signed [sma_pkg::SAMPLE_W+1:0] qsigned;
	logic load_out;

	assign two_h    = {half_width, 1'b0};
	assign span     = {1'b0, half_width, 1'b1};
	assign rd_mag   = rd_q[ENT_W-1 -: sma_pkg::MAG_W];
	assign prod_abs = prod_s1[31] ? -prod_s1 : prod_s1;
	assign qsigned  = neg_q ? -$signed({2'b00, div_rsp.quot[sma_pkg::SAMPLE_W-1:0]})
	                        : $signed({2'b00, div_rsp.quot[sma_pkg::SAMPLE_W-1:0]});
	assign load_out = (state_q == B_OUT) && (!out_valid_q || out_ready);
	assign q_pop    = (state_q == B_IDLE) && !rc_pend_q && !q_empty;

	assign out_valid = out_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;
	assign out_last  = out_last_q;

	always_comb begin
		mem_we = (state_q == B_SHIFT);
		mem_wa = wp_q + 1'b1;
		mem_re = 1'b0;
		mem_ra = wp_q;
		unique case (state_q)
			B_RC_RD: begin
				mem_re = 1'b1;
				mem_ra = wp_q - idx_q;
			end
			B_SHIFT: begin
				// entry that drops out of the window after this shift
				mem_re = 1'b1;
				mem_ra = wp_q - two_h;
			end
			B_ACC: begin
				// center bin
				mem_re = 1'b1;
				mem_ra = wp_q - {1'b0, half_width};
			end
			default: ;
		endcase
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = prod_abs;
		div_req.divisor  = ctr_mag_q;
		unique case (state_q)
			B_CAP: begin
				div_req.start    = 1'b1;
				div_req.dividend = {{(sma_pkg::DVD_W-sma_pkg::SUM_W){1'b0}}, sum_q};
				div_req.divisor  = {{(sma_pkg::DSR_W-sma_pkg::FILL_W){1'b0}}, span};
			end
			B_SRE, B_SIM: div_req.start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= {cur_q.mag, cur_q.re, cur_q.im};
		if (mem_re) rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			wp_q        <= '0;
			idx_q       <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			flush_q     <= '0;
			rc_pend_q   <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rc_req) rc_pend_q <= 1'b1;
			else if (state_q == B_RC_ACC && idx_q == two_h) rc_pend_q <= 1'b0;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (rc_pend_q) begin
						sum_q   <= '0;
						idx_q   <= '0;
						state_q <= B_RC_RD;
					end else if (!q_empty) begin
						last_q  <= q_item.last;
						flush_q <= q_item.last ? half_width : '0;
						state_q <= B_SHIFT;
					end
				end
				B_RC_RD: state_q <= B_RC_ACC;
				B_RC_ACC: begin
					if ({1'b0, idx_q} < fill_q) sum_q <= sum_q + sma_pkg::SUM_W'(rd_mag);
					if (idx_q == two_h) begin
						state_q   <= B_IDLE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= B_RC_RD;
					end
				end
				B_SHIFT: begin
					wp_q    <= wp_q + 1'b1;
					if (fill_q != '1) fill_q <= fill_q + 1'b1;
					state_q <= B_ACC;
				end
				B_ACC: begin
					sum_q <= sum_q + sma_pkg::SUM_W'(cur_q.mag)
					       - ((span < fill_q) ? sma_pkg::SUM_W'(rd_mag) : '0);
					if (fill_q > {2'b00, half_width}) state_q <= B_CAP;
					else state_q <= B_NEXT;
				end
				B_CAP: state_q <= B_DAVG;
				B_DAVG: begin
					if (div_rsp.done) begin
						if (ctr_mag_q == '0) state_q <= B_OUT;
						else state_q <= B_MRE;
					end
				end
				B_MRE: state_q <= B_SRE;
				B_SRE: state_q <= B_DRE;
				B_DRE: if (div_rsp.done) state_q <= B_MIM;
				B_MIM: state_q <= B_SIM;
				B_SIM: state_q <= B_DIM;
				B_DIM: if (div_rsp.done) state_q <= B_OUT;
				B_OUT: if (load_out) state_q <= B_NEXT;
				B_NEXT: begin
					if (flush_q != '0) begin
						flush_q <= flush_q - 1'b1;
						state_q <= B_SHIFT;
					end else begin
						// frame end: clear the window
						if (last_q) begin
							fill_q <= '0;
							sum_q  <= '0;
						end
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_item;
		if (state_q == B_NEXT) cur_q <= '0;
		if (state_q == B_ACC) elast_q <= last_q && (flush_q == '0);
		if (state_q == B_CAP) begin
			ctr_mag_q <= rd_q[ENT_W-1 -: sma_pkg::MAG_W];
			ctr_re_q  <= rd_q[2*sma_pkg::SAMPLE_W-1 -: sma_pkg::SAMPLE_W];
			ctr_im_q  <= rd_q[sma_pkg::SAMPLE_W-1:0];
		end
		if (state_q == B_DAVG && div_rsp.done) begin
			avg_q <= div_rsp.quot[sma_pkg::MAG_W-1:0];
			ore_q <= sma_pkg::sat16($signed({2'b00, div_rsp.quot[sma_pkg::MAG_W-1:0]}));
			oim_q <= '0;
		end
		if (state_q == B_MRE) prod_s1 <= $signed({1'b0, avg_q}) * ctr_re_q;
		if (state_q == B_MIM) prod_s1 <= $signed({1'b0, avg_q}) * ctr_im_q;
		if (state_q == B_SRE || state_q == B_SIM) neg_q <= prod_s1[31];
		if (state_q == B_DRE && div_rsp.done) ore_q <= sma_pkg::sat16(qsigned);
		if (state_q == B_DIM && div_rsp.done) oim_q <= sma_pkg::sat16(qsigned);
		if (load_out) begin
			out_re_q   <= ore_q;
			out_im_q   <= oim_q;
			out_last_q <= elast_q;
		end
	end

endmodule
`default_nettype wire

[hdl/spectral_magnitude_window_average.sv]
// Top level of the spectral magnitude window averager.
//
// Each bin's magnitude is found in the front by accept, squares, sum, then a
// 16-step root, then the queue push. In the back a bin without a result takes no
// division; each result is set by three 32-step divisions in the one shared
// serial divider (average, then real and imaginary scaling), plus any output
// stall; a zero-magnitude center bin needs only the average. A frame end adds
// half_width flush shifts, each with a result once its center bin lies in the
// frame. After a half_width write the back re-sums the window before it takes
// the next bin. A 4-entry queue lets the front take bins while the back works.
`default_nettype none
module spectral_magnitude_window_average (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // bin_re [15:0], bin_im [31:16]
	input  wire         s_tlast,   // frame_end
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // out_re [15:0], out_im [31:16]
	output logic        m_tlast,   // out_last
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [4:0]  cfg_data   // half_width
);

	logic [sma_pkg::HW_W-1:0] half_width_q;
	logic push, pop, q_full, q_empty;
	sma_pkg::item_t push_item, head;
	sma_pkg::div_req_t div_req;
	sma_pkg::div_rsp_t div_rsp;
	logic signed [sma_pkg::SAMPLE_W-1:0] o_re, o_im;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {o_im, o_re};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= '0;
		end else if (cfg_valid) begin
			half_width_q <= cfg_data;
		end
	end

	sma_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_re    (s_tdata[15:0]),
		.in_im    (s_tdata[31:16]),
		.in_last  (s_tlast),
		.push     (push),
		.push_item(push_item),
		.q_full   (q_full)
	);

	sma_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	sma_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	sma_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.half_width(half_width_q),
		.rc_req    (cfg_valid),
		.q_empty   (q_empty),
		.q_pop     (pop),
		.q_item    (head),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_re    (o_re),
		.out_im    (o_im),
		.out_last  (m_tlast)
	);

endmodule
`default_nettype wire

[hdl/sma_checker.sv]
// Port-level checks of the averager, bound to the top level.
`default_nettype none
module sma_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [31:0] m_tdata,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire        m_tlast,
	input wire        cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("front took a second request while computing magnitude");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel not ready");

endmodule

bind spectral_magnitude_window_average sma_checker u_chk (.*);
`default_nettype wire
